[sv/hcld_pkg.sv]
// shared types and constants for the hotkey command line dispatcher
package hcld_pkg;

  localparam logic [7:0] CR_CODE     = 8'd13;
  localparam logic [7:0] PREFIX_CODE = 8'd37;
  localparam int unsigned MIN_LINE   = 3;

  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_KEY      = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [7:0] handler_id;
  } in_t;

  typedef struct packed {
    logic [7:0] dest_handler;
    logic       found;
    logic [7:0] payload_char;
    logic [4:0] payload_length;
    logic       last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic scan;
    logic prep;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_scan;
    logic scan_done;
    logic emit_done;
  } sts_t;

endpackage

[sv/hcld_ram.sv]
// generic single write port ram with registered read
module hcld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hcld_ctrl.sv]
// sequencing state machine: idle, table scan, read prefetch, payload emit
module hcld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  hcld_pkg::sts_t    sts,
  output hcld_pkg::cmd_t    cmd,
  output logic              busy
);

  hcld_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcld_pkg::ST_IDLE: if (sts.go_scan) state_nxt = hcld_pkg::ST_SCAN;
      hcld_pkg::ST_SCAN: if (sts.scan_done) state_nxt = hcld_pkg::ST_PREP;
      hcld_pkg::ST_PREP: state_nxt = hcld_pkg::ST_EMIT;
      hcld_pkg::ST_EMIT: if (sts.emit_done) state_nxt = hcld_pkg::ST_IDLE;
      default:           state_nxt = hcld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcld_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.idle = (state_r == hcld_pkg::ST_IDLE);
  assign cmd.scan = (state_r == hcld_pkg::ST_SCAN);
  assign cmd.prep = (state_r == hcld_pkg::ST_PREP);
  assign cmd.emit = (state_r == hcld_pkg::ST_EMIT);
  assign busy     = !cmd.idle;

endmodule

[sv/hcld_dp.sv]
// datapath: line buffer, command table, counters, scan and emit pointers
module hcld_dp #(
  parameter int LINE_DEPTH  = 30,
  parameter int TABLE_DEPTH = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  hcld_pkg::in_t   in_data,
  input  hcld_pkg::cmd_t  cmd,
  output hcld_pkg::sts_t  sts,
  output logic            out_valid,
  output hcld_pkg::out_t  out_data
);

  localparam int LCW = $clog2(LINE_DEPTH + 1);
  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [LCW-1:0] line_count_r, line_count_nxt;
  logic [TCW-1:0] entry_count_r, entry_count_nxt;
  logic [7:0]     first_r, first_nxt;
  logic [7:0]     second_r, second_nxt;
  logic [TCW-1:0] idx_r, idx_nxt;
  logic           pend_r, pend_nxt;
  logic           hit_r, hit_nxt;
  logic [7:0]     dest_r, dest_nxt;
  logic [LCW-1:0] ptr_r, ptr_nxt;

  logic        accept, key, is_cr, bad_cr, line_full, store, tbl_we;
  logic        match_now;
  logic [15:0] tbl_rdata;
  logic [7:0]  line_rdata;
  logic [LCW-1:0] pay_len;

  assign accept    = cmd.idle && start;
  assign key       = accept && (in_data.kind == hcld_pkg::KIND_KEY);
  assign is_cr     = (in_data.char_code == hcld_pkg::CR_CODE);
  assign line_full = (line_count_r >= LCW'(LINE_DEPTH));
  assign bad_cr    = key && is_cr &&
                     ((line_count_r < LCW'(hcld_pkg::MIN_LINE)) || line_full);
  assign store     = key && !bad_cr && !line_full;
  assign tbl_we    = accept && (in_data.kind == hcld_pkg::KIND_REGISTER) &&
                     (entry_count_r < TCW'(TABLE_DEPTH));

  assign match_now     = pend_r && (tbl_rdata[15:8] == second_r);
  assign sts.go_scan   = store && is_cr && (first_r == hcld_pkg::PREFIX_CODE);
  assign sts.scan_done = cmd.scan && (match_now || (idx_r >= entry_count_r));
  assign sts.emit_done = cmd.emit && (ptr_r == line_count_r);

  hcld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (store),
    .waddr (line_count_r[LAW-1:0]),
    .wdata (in_data.char_code),
    .raddr (ptr_r[LAW-1:0]),
    .rdata (line_rdata)
  );

  hcld_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (entry_count_r[TAW-1:0]),
    .wdata ({in_data.char_code, in_data.handler_id}),
    .raddr (idx_r[TAW-1:0]),
    .rdata (tbl_rdata)
  );

  always_comb begin
    line_count_nxt  = line_count_r;
    entry_count_nxt = entry_count_r;
    first_nxt       = first_r;
    second_nxt      = second_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    hit_nxt         = hit_r;
    dest_nxt        = dest_r;
    ptr_nxt         = ptr_r;

    if (tbl_we) begin
      entry_count_nxt = entry_count_r + TCW'(1);
    end
    if (bad_cr) begin
      line_count_nxt = '0;
    end
    if (store) begin
      line_count_nxt = line_count_r + LCW'(1);
      if (line_count_r == LCW'(0)) first_nxt = in_data.char_code;
      if (line_count_r == LCW'(1)) second_nxt = in_data.char_code;
      // complete line without the prefix: drop it
      if (is_cr && (first_r != hcld_pkg::PREFIX_CODE)) line_count_nxt = '0;
    end
    if (sts.go_scan) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      hit_nxt  = 1'b0;
      dest_nxt = '0;
    end

    if (cmd.scan) begin
      if (match_now) begin
        hit_nxt  = 1'b1;
        dest_nxt = tbl_rdata[7:0];
      end
      if (sts.scan_done) begin
        ptr_nxt = LCW'(2);
      end else begin
        idx_nxt  = idx_r + TCW'(1);
        pend_nxt = 1'b1;
      end
    end

    if (cmd.prep || cmd.emit) begin
      ptr_nxt = ptr_r + LCW'(1);
    end
    if (sts.emit_done) begin
      line_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r  <= '0;
      entry_count_r <= '0;
      pend_r        <= 1'b0;
    end else begin
      line_count_r  <= line_count_nxt;
      entry_count_r <= entry_count_nxt;
      pend_r        <= pend_nxt;
    end
    first_r  <= first_nxt;
    second_r <= second_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    dest_r   <= dest_nxt;
    ptr_r    <= ptr_nxt;
  end

  assign pay_len   = line_count_r - LCW'(2);
  assign out_valid = cmd.emit;

  always_comb begin
    out_data.dest_handler   = dest_r;
    out_data.found          = hit_r;
    out_data.payload_char   = line_rdata;
    out_data.payload_length = 5'(pay_len);
    out_data.last           = sts.emit_done;
  end

  a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (line_count_r <= LCW'(LINE_DEPTH)) && (entry_count_r <= TCW'(TABLE_DEPTH)))
    else $error("line or table count out of range");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.dest_handler == 8'd0))
    else $error("dest handler nonzero without a match");

  a_emit_long_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (line_count_r >= LCW'(hcld_pkg::MIN_LINE)))
    else $error("emit on a short line");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> (line_count_r == '0))
    else $error("line not cleared after dispatch");

  a_scan_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.go_scan |-> cmd.idle)
    else $error("dispatch started while busy");

endmodule

[sv/hotkey_command_line_dispatcher.sv]
// top level of the hotkey command line dispatcher
//
//  channel  ports                       direction  transfer
//  request  start, busy, in_data        in         start && !busy
//  result   out_valid, out_data         out        out_valid, one cycle each
//
// register requests and ordinary keystrokes leave busy low
// a carriage return that dispatches runs a table scan that stops at the
//   first matching entry, or after the last entry on a miss, then
//   a line buffer prefetch, then n results,
//   n = stored length - 2; busy is high throughout
// the table scan and the payload emit are paced by one registered read
//   port on each ram
// reset (rst_n low, synchronous) empties the line buffer and the table
// results cannot be stalled; out_valid pulses once per payload character
module hotkey_command_line_dispatcher #(
  parameter int LINE_DEPTH  = 30,
  parameter int TABLE_DEPTH = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  hcld_pkg::in_t   in_data,
  output logic            out_valid,
  output hcld_pkg::out_t  out_data
);

  hcld_pkg::cmd_t cmd;
  hcld_pkg::sts_t sts;

  // state machine: decides when the datapath scans and emits
  hcld_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and counters; takes requests only while the controller is idle
  hcld_dp #(
    .LINE_DEPTH  (LINE_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/hcld_dispatch_checker.sv]
// predictor and result checker for the hotkey command line dispatcher
module hcld_dispatch_checker #(
  parameter int LINE_DEPTH  = 30,
  parameter int TABLE_DEPTH = 28
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  hcld_pkg::in_t  in_data,
  input  logic           out_valid,
  input  hcld_pkg::out_t out_data,
  output int             fail_count,
  output int             outstanding
);

  logic [7:0]     line_buf [LINE_DEPTH];
  int unsigned    line_len;
  logic [7:0]     letters  [TABLE_DEPTH];
  logic [7:0]     handlers [TABLE_DEPTH];
  int unsigned    entries;
  hcld_pkg::out_t awaited_chars [$];
  int             mismatches = 0;

  // update the line and table, queue the payload characters a dispatch emits
  task automatic model_request(input hcld_pkg::in_t req);
    logic           hit;
    logic [7:0]     dest;
    int unsigned    n;
    hcld_pkg::out_t res;
    hit  = 1'b0;
    dest = '0;
    if (req.kind == hcld_pkg::KIND_REGISTER) begin
      if (entries < TABLE_DEPTH) begin
        letters[entries]  = req.char_code;
        handlers[entries] = req.handler_id;
        entries++;
      end
      return;
    end
    if (req.char_code == hcld_pkg::CR_CODE &&
        (line_len < hcld_pkg::MIN_LINE || line_len >= LINE_DEPTH)) begin
      line_len = 0;
      return;
    end
    if (line_len >= LINE_DEPTH) return;
    line_buf[line_len] = req.char_code;
    line_len++;
    if (req.char_code != hcld_pkg::CR_CODE) return;
    if (line_buf[0] == hcld_pkg::PREFIX_CODE) begin
      for (int k = 0; k < entries; k++) begin
        if (!hit && letters[k] == line_buf[1]) begin
          hit  = 1'b1;
          dest = handlers[k];
        end
      end
      n = line_len - 2;
      for (int k = 0; k < n; k++) begin
        res.dest_handler   = dest;
        res.found          = hit;
        res.payload_char   = line_buf[k + 2];
        res.payload_length = 5'(n);
        res.last           = (k + 1 == n);
        awaited_chars.push_back(res);
      end
    end
    line_len = 0;
  endtask

  task automatic compare_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hcld_pkg::out_t exp_res;
    if (!rst_n) begin
      line_len = 0;
      entries  = 0;
      awaited_chars.delete();
    end else begin
      if (start && !busy) model_request(in_data);
      if (out_valid) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
          mismatches++;
        end else begin
          exp_res = awaited_chars.pop_front();
          compare_field("dest_handler", exp_res.dest_handler, out_data.dest_handler);
          compare_field("found", 8'(exp_res.found), 8'(out_data.found));
          compare_field("payload_char", exp_res.payload_char, out_data.payload_char);
          compare_field("payload_length", 8'(exp_res.payload_length),
                        8'(out_data.payload_length));
          compare_field("last", 8'(exp_res.last), 8'(out_data.last));
        end
      end
    end
    outstanding <= awaited_chars.size();
    fail_count  <= mismatches;
  end

endmodule

[tb/tb.sv]
// testbench top: request stimulus and verdict for the hotkey command line dispatcher
module tb;

  localparam int LINE_DEPTH  = 30;
  localparam int TABLE_DEPTH = 28;
  localparam int ITEM_TARGET = 400;
  // results trail the last request by at most a table scan plus a full payload
  localparam int TAIL_CYCLES = 64;
  localparam int POOL_SIZE   = 12;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  hcld_pkg::in_t  in_data;
  logic           out_valid;
  hcld_pkg::out_t out_data;
  int             fail_count;
  int             outstanding;

  // counters of the stimulus side
  int sent_items    = 0;
  int registrations = 0;
  int burst_left    = 1;
  logic [7:0] letter_pool [POOL_SIZE];

  always #4 clk = ~clk;

  hotkey_command_line_dispatcher #(
    .LINE_DEPTH (LINE_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // watches both channels, predicts every payload character and compares
  hcld_dispatch_checker #(
    .LINE_DEPTH (LINE_DEPTH),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dispatch_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // any byte but carriage return, so a line is not ended early
  function automatic logic [7:0] plain_char();
    int c;
    c = $urandom_range(0, 254);
    if (c >= hcld_pkg::CR_CODE) c++;
    return 8'(c);
  endfunction

  // keystroke request; the handler field is ignored by the block, so it is noise
  function automatic hcld_pkg::in_t key_req(input logic [7:0] c);
    return '{kind: hcld_pkg::KIND_KEY, char_code: c,
             handler_id: 8'($urandom_range(0, 255))};
  endfunction

  // payload lengths: mostly short, some anywhere up to the longest line, some the longest
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 4);
    if (r < 19) return $urandom_range(1, LINE_DEPTH - 3);
    return LINE_DEPTH - 3;
  endfunction

  // drive one request and hold it until the block takes it; then maybe idle
  // a while between bursts, so start also goes low at random points
  task automatic push(input hcld_pkg::in_t req, input bit counts);
    int gap;
    start   <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (counts) sent_items++;
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      if (gap > 0) begin
        start   <= 1'b0;
        in_data <= '{kind: 1'($urandom), char_code: 8'($urandom),
                     handler_id: 8'($urandom)};
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // table entries beyond the table size are ignored by the block
  task automatic enroll(input logic [7:0] letter, input logic [7:0] id);
    push('{kind: hcld_pkg::KIND_REGISTER, char_code: letter, handler_id: id},
         registrations < TABLE_DEPTH);
    registrations++;
  endtask

  // well-formed command: prefix, letter, payload, carriage return
  task automatic command_line(input logic [7:0] letter, input int payload_len);
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);
    push(key_req(letter), 1'b1);
    repeat (payload_len) push(key_req(plain_char()), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
  endtask

  // fill the line buffer, drop a few more, then a carriage return clears it
  task automatic overfull_line(input int extra);
    push(key_req($urandom_range(0, 1) ? hcld_pkg::PREFIX_CODE : plain_char()), 1'b1);
    repeat (LINE_DEPTH - 1) push(key_req(plain_char()), 1'b1);
    repeat (extra) push(key_req(plain_char()), 1'b0);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
  endtask

  initial begin
    int         sel;
    int         n;
    logic [7:0] c;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    letter_pool[0] = hcld_pkg::PREFIX_CODE;
    letter_pool[1] = 8'h00;
    letter_pool[2] = 8'hFF;
    for (int i = 3; i < POOL_SIZE; i++) letter_pool[i] = plain_char();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short lines, a miss on an empty table, duplicate letters
    // where the first entry wins, extreme bytes and a line without the prefix
    push(key_req(hcld_pkg::CR_CODE), 1'b1);        // empty line
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);    // one stored character
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);    // two stored characters
    push(key_req(8'h61), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);    // shortest dispatch, no handler
    push(key_req(8'h61), 1'b1);
    push(key_req(8'h78), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
    enroll(8'h61, 8'hFF);
    enroll(8'h61, 8'h00);                           // shadowed by the first entry
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);
    push(key_req(8'h61), 1'b1);
    push(key_req(8'hFF), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
    push(key_req(8'h78), 1'b1);                    // no prefix, cleared silently
    push(key_req(8'h61), 1'b1);
    push(key_req(8'h62), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);
    enroll(8'h00, 8'hA5);
    push(key_req(hcld_pkg::PREFIX_CODE), 1'b1);
    push(key_req(8'h00), 1'b1);
    push(key_req(8'h00), 1'b1);
    push(key_req(hcld_pkg::CR_CODE), 1'b1);

    // random: mostly well-formed commands, the table filled along the way,
    // plus noise, lines without prefix, short lines and overfull lines;
    // every key sequence ends with a carriage return so the next one starts clean
    while (sent_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 12 && registrations < TABLE_DEPTH + 6) begin
        repeat ($urandom_range(1, 6)) begin
          c = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : letter_pool[$urandom_range(0, POOL_SIZE - 1)];
          enroll(c, 8'($urandom_range(0, 255)));
        end
      end else if (sel < 72) begin
        c = ($urandom_range(0, 6) == 0) ? plain_char()
                                        : letter_pool[$urandom_range(0, POOL_SIZE - 1)];
        command_line(c, pick_length());
      end else if (sel < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: c = hcld_pkg::CR_CODE;
            1: c = hcld_pkg::PREFIX_CODE;
            default: c = 8'($urandom_range(0, 255));
          endcase
          push(key_req(c), 1'b1);
        end
        push(key_req(hcld_pkg::CR_CODE), 1'b1);
      end else if (sel < 86) begin
        do c = plain_char(); while (c == hcld_pkg::PREFIX_CODE);
        push(key_req(c), 1'b1);
        repeat ($urandom_range(2, 8)) push(key_req(plain_char()), 1'b1);
        push(key_req(hcld_pkg::CR_CODE), 1'b1);
      end else if (sel < 92) begin
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
          push(key_req((i == 0 && $urandom_range(0, 1)) ? hcld_pkg::PREFIX_CODE
                                                        : plain_char()), 1'b1);
        push(key_req(hcld_pkg::CR_CODE), 1'b1);
      end else begin
        overfull_line($urandom_range(0, 4));
      end
    end

    // drain: let the last dispatch finish, then a short quiet tail
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      if (outstanding != 0) $display("%0t: %0d expected results never arrived", $time,
                                     outstanding);
      $display("status: fail");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("status: fail");
    $finish;
  end

endmodule

[sim.f]
sv/hcld_pkg.sv
sv/hcld_ram.sv
sv/hcld_ctrl.sv
sv/hcld_dp.sv
sv/hotkey_command_line_dispatcher.sv
tb/hcld_dispatch_checker.sv
tb/tb.sv
